[hdl/gof_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gof_pkg: shared types and constants of the group-one ALU
// Operation codes, beat payload structs, the classified item that moves
// from the front part to the back part, and the cycle-cost tables.
// ----------------------------------------------------------------------------
package gof_pkg;

  typedef enum logic [2:0] {
    OP_ORA = 3'd0,
    OP_AND = 3'd1,
    OP_EOR = 3'd2,
    OP_ADC = 3'd3,
    OP_STA = 3'd4,
    OP_LDA = 3'd5,
    OP_CMP = 3'd6,
    OP_SBC = 3'd7
  } op_e;

  localparam logic [2:0] MODE_IMM = 3'd2;
  localparam int unsigned SIGN_BIT = 7;

  // Cycle cost per addressing mode; a store never uses the immediate entry.
  localparam logic [2:0] READ_COST  [8] = '{3'd6, 3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4};
  localparam logic [2:0] STORE_COST [8] = '{3'd6, 3'd3, 3'd0, 3'd4, 3'd6, 3'd4, 3'd5, 3'd5};

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  mode;
    logic [7:0]  operand_byte;
    logic [15:0] effective_address;
    logic        crossed_page;
  } in_t;

  typedef struct packed {
    logic [7:0]  accumulator;
    logic        flag_carry;
    logic        flag_overflow;
    logic        flag_zero;
    logic        flag_negative;
    logic        store_valid;
    logic [15:0] store_address;
    logic [7:0]  store_data;
    logic [2:0]  cycles_taken;
    logic [31:0] cycle_total;
    logic        illegal_mode;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic        illegal;
    logic [2:0]  cost;
    logic [7:0]  operand;
    logic [15:0] address;
  } cls_t;

endpackage
`default_nettype wire

[hdl/group_one_alu_6502.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// group_one_alu_6502: 6502 group-one instruction unit, binary mode
// Executes ORA, AND, EOR, ADC, STA, LDA, CMP and SBC on an internal
// accumulator and the C, V, Z and N flags.
//
// Input channel: one instruction beat (operation, addressing mode, operand
// byte, effective address, page-cross bit) on in_valid_i / in_ready_o.
// Output channel: one result beat per instruction on out_valid_o /
// out_ready_i, carrying the new accumulator and flags, an optional store
// request, the cycle cost and the wrapping 32-bit cycle total.
// The result passes through the classify register, loaded at acceptance,
// then the queue and then the output register, which drives output valid.
// Throughput is one instruction per cycle while the receiver does not stall;
// the flag and accumulator feedback stays within the execute stage.
// Reset clears the accumulator, the flags, the cycle total and all queues.
// When the receiver stalls the result register holds, the execute stage
// stops, the queue fills and then in_ready_o falls; nothing is dropped.
// ----------------------------------------------------------------------------
module group_one_alu_6502 import gof_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  cls_t fr_data, bk_data;

  gof_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cls_valid_o (fr_valid),
    .cls_ready_i (fr_ready),
    .cls_data_o  (fr_data)
  );

  gof_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_data),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  gof_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (bk_valid),
    .cls_ready_o (bk_ready),
    .cls_data_i  (bk_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[hdl/gof_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gof_front: accept and classify
// Decodes each input beat into an operation, an illegal-store flag and the
// cycle cost, and holds the classified item in a register stage.
// ----------------------------------------------------------------------------
module gof_front import gof_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      cls_valid_o,
  input  wire logic cls_ready_i,
  output cls_t      cls_data_o
);

  logic cls_valid_q, cls_valid_d;
  cls_t cls_q, cls_d;
  op_e  op;

  assign in_ready_o = !cls_valid_q || cls_ready_i;

  always_comb begin
    op            = op_e'(in_data_i.req_type);
    cls_d.op      = op;
    cls_d.illegal = (op == OP_STA) && (in_data_i.mode == MODE_IMM);
    cls_d.operand = in_data_i.operand_byte;
    cls_d.address = in_data_i.effective_address;
    if (cls_d.illegal) begin
      cls_d.cost = 3'd0;
    end else if (op == OP_STA) begin
      cls_d.cost = STORE_COST[in_data_i.mode];
    end else begin
      // Largest read cost is six, so the page-cross cycle still fits.
      cls_d.cost = READ_COST[in_data_i.mode] + {2'b00, in_data_i.crossed_page};
    end
    cls_valid_d = in_ready_o ? in_valid_i : cls_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_valid_q <= 1'b0;
    end else begin
      cls_valid_q <= cls_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = cls_valid_q;
  assign cls_data_o  = cls_q;

endmodule
`default_nettype wire

[hdl/gof_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gof_queue: classified-item queue
// A small first-in first-out buffer that decouples the front part from the
// back part, so that each may stall on its own.
// ----------------------------------------------------------------------------
module gof_queue import gof_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cls_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cls_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cls_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    push     = push_valid_i && push_ready_o;
    pop      = pop_valid_o && pop_ready_i;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[hdl/gof_exec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gof_exec: execute and deliver
// Holds the accumulator, flags and running cycle total; executes one classified
// item per cycle unless the output stalls; the result goes to the output register.
// ----------------------------------------------------------------------------
module gof_exec import gof_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cls_valid_i,
  output logic      cls_ready_o,
  input  wire cls_t cls_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic [7:0]  acc_q, acc_d;
  logic        c_q, c_d, v_q, v_d, z_q, z_d, n_q, n_d;
  logic [31:0] total_q, total_d;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        take;
  logic [7:0]  addend;
  logic        cin;
  logic [8:0]  sum;

  assign cls_ready_o = !out_valid_q || out_ready_i;
  assign take        = cls_valid_i && cls_ready_o;

  always_comb begin
    // SBC and CMP both add the inverted operand; CMP always with a carry in.
    addend  = ((cls_data_i.op == OP_SBC) || (cls_data_i.op == OP_CMP)) ?
              ~cls_data_i.operand : cls_data_i.operand;
    cin     = (cls_data_i.op == OP_CMP) ? 1'b1 : c_q;
    sum     = {1'b0, acc_q} + {1'b0, addend} + {8'd0, cin};
    acc_d   = acc_q;
    c_d     = c_q;
    v_d     = v_q;
    z_d     = z_q;
    n_d     = n_q;
    total_d = total_q + {29'd0, cls_data_i.cost};
    if (!cls_data_i.illegal) begin
      case (cls_data_i.op)
        OP_ORA: acc_d = acc_q | cls_data_i.operand;
        OP_AND: acc_d = acc_q & cls_data_i.operand;
        OP_EOR: acc_d = acc_q ^ cls_data_i.operand;
        OP_LDA: acc_d = cls_data_i.operand;
        OP_ADC, OP_SBC: begin
          acc_d = sum[7:0];
          c_d   = sum[8];
          v_d   = (acc_q[SIGN_BIT] ^ sum[SIGN_BIT]) & (addend[SIGN_BIT] ^ sum[SIGN_BIT]);
        end
        OP_CMP: c_d = sum[8];
        default: ;
      endcase
      if (cls_data_i.op == OP_CMP) begin
        z_d = (sum[7:0] == 8'd0);
        n_d = sum[SIGN_BIT];
      end else if (cls_data_i.op != OP_STA) begin
        z_d = (acc_d == 8'd0);
        n_d = acc_d[SIGN_BIT];
      end
    end

    out_d.accumulator   = acc_d;
    out_d.flag_carry    = c_d;
    out_d.flag_overflow = v_d;
    out_d.flag_zero     = z_d;
    out_d.flag_negative = n_d;
    out_d.store_valid   = (cls_data_i.op == OP_STA) && !cls_data_i.illegal;
    out_d.store_address = out_d.store_valid ? cls_data_i.address : 16'd0;
    out_d.store_data    = out_d.store_valid ? acc_q : 8'd0;
    out_d.cycles_taken  = cls_data_i.cost;
    out_d.cycle_total   = total_d;
    out_d.illegal_mode  = cls_data_i.illegal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 8'd0;
      c_q         <= 1'b0;
      v_q         <= 1'b0;
      z_q         <= 1'b0;
      n_q         <= 1'b0;
      total_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        acc_q   <= acc_d;
        c_q     <= c_d;
        v_q     <= v_d;
        z_q     <= z_d;
        n_q     <= n_d;
        total_q <= total_d;
      end
      if (cls_ready_o) begin
        out_valid_q <= cls_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[hdl/gof_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gof_checker: port-level checks of the group-one ALU
// Watches the output channel and checks the result beats for consistency.
// ----------------------------------------------------------------------------
module gof_checker import gof_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  logic        seen_q;
  logic [31:0] last_total_q;

  // Cycle total of the most recently delivered beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_total_q <= 32'd0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q       <= 1'b1;
      last_total_q <= out_data_o.cycle_total;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q |->
      out_data_o.cycle_total == last_total_q + {29'd0, out_data_o.cycles_taken})
    else $error("cycle total does not advance by the cycle cost");

  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.illegal_mode |->
      !out_data_o.store_valid && out_data_o.cycles_taken == 3'd0)
    else $error("illegal store produced a store or a cost");

  a_no_stray_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.store_valid |->
      out_data_o.store_address == 16'd0 && out_data_o.store_data == 8'd0)
    else $error("store fields set without a store request");

endmodule

bind group_one_alu_6502 gof_checker u_gof_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

[sim/tb_group_one_alu_6502.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_one_alu_6502: self-checking bench for the group-one ALU
// A short directed table covers every operation, every addressing mode,
// the flag corner cases and the illegal immediate store. A long random run
// follows. Both channels idle and stall at random, including one long
// receiver hold and one full drain. Every result beat is checked field by
// field against a bench-side model of the accumulator, flags and cycle total.
// ----------------------------------------------------------------------------
module tb_group_one_alu_6502;
  import gof_pkg::*;

  localparam int unsigned RandomItems = 850;
  localparam int unsigned CycleLimit  = 200000;

  // Cycle cost per mode, mode 0 in the lowest three bits.
  localparam logic [23:0] READ_CYCLES  = {3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd2, 3'd3, 3'd6};
  localparam logic [23:0] STORE_CYCLES = {3'd5, 3'd5, 3'd4, 3'd6, 3'd4, 3'd0, 3'd3, 3'd6};
  localparam logic [39:0] EDGE_BYTES   = {8'hFF, 8'h80, 8'h7F, 8'h01, 8'h00};

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Bench copy of the architectural state.
  logic [7:0]  acc;
  logic        c_flag;
  logic        v_flag;
  logic        z_flag;
  logic        n_flag;
  logic [31:0] cycle_sum;

  out_t        expected_results[$];
  stim_row_t   directed_rows[$];
  int unsigned beats_taken;
  int unsigned err_count;
  int unsigned cycle_count;

  group_one_alu_6502 u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stim_row_t row(op_e op, logic [2:0] mode, logic [7:0] opnd,
                                    logic [15:0] addr, logic pc, bit typed, out_t want);
    stim_row_t r;
    r.beat  = '{req_type: op, mode: mode, operand_byte: opnd,
                effective_address: addr, crossed_page: pc};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Runs one instruction on the bench state and returns the result beat it should give.
  function automatic out_t exec_group_one(in_t beat);
    out_t       r;
    op_e        op;
    logic [2:0] cost;
    logic [7:0] m;
    logic [7:0] diff;
    logic [8:0] sum;
    r    = '0;
    cost = 3'd0;
    op   = op_e'(beat.req_type);
    if (op == OP_STA) begin
      if (beat.mode == MODE_IMM) begin
        r.illegal_mode = 1'b1;
      end else begin
        r.store_valid   = 1'b1;
        r.store_address = beat.effective_address;
        r.store_data    = acc;
        cost            = STORE_CYCLES[beat.mode*3 +: 3];
      end
    end else begin
      cost = READ_CYCLES[beat.mode*3 +: 3] + {2'b00, beat.crossed_page};
      case (op)
        OP_ORA: acc = acc | beat.operand_byte;
        OP_AND: acc = acc & beat.operand_byte;
        OP_EOR: acc = acc ^ beat.operand_byte;
        OP_LDA: acc = beat.operand_byte;
        OP_CMP: begin
          c_flag = (acc >= beat.operand_byte);
          diff   = acc - beat.operand_byte;
        end
        default: begin
          // SBC is ADC of the inverted operand; carry set means no borrow.
          m      = (op == OP_SBC) ? ~beat.operand_byte : beat.operand_byte;
          sum    = {1'b0, acc} + {1'b0, m} + {8'd0, c_flag};
          v_flag = (acc[7] ^ sum[7]) & (m[7] ^ sum[7]);
          c_flag = sum[8];
          acc    = sum[7:0];
        end
      endcase
      if (op == OP_CMP) begin
        z_flag = (diff == 8'h00);
        n_flag = diff[7];
      end else begin
        z_flag = (acc == 8'h00);
        n_flag = acc[7];
      end
    end
    cycle_sum       = cycle_sum + {29'd0, cost};
    r.accumulator   = acc;
    r.flag_carry    = c_flag;
    r.flag_overflow = v_flag;
    r.flag_zero     = z_flag;
    r.flag_negative = n_flag;
    r.cycles_taken  = cost;
    r.cycle_total   = cycle_sum;
    return r;
  endfunction

  // Stretches of 24 beats in every 128 with no idle gaps keep both sides busy back to back.
  function automatic int unsigned idle_cycles(int unsigned n);
    return ((n % 128) < 24) ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result beat %0d, %s: got %0h, want %0h", beats_taken, what, got, want);
    err_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(stim_row_t r, int unsigned idx);
    int unsigned gap;
    out_t        predicted;
    gap = idle_cycles(idx);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.beat;
    do @(posedge clk); while (!in_ready);
    predicted = exec_group_one(r.beat);
    expected_results.push_back(r.typed ? r.want : predicted);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[group_one_alu_6502] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'd0, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.accumulator !== want.accumulator)
          report_mismatch("accumulator", 32'(out_data.accumulator), 32'(want.accumulator));
        if (out_data.flag_carry !== want.flag_carry)
          report_mismatch("flag_carry", 32'(out_data.flag_carry), 32'(want.flag_carry));
        if (out_data.flag_overflow !== want.flag_overflow)
          report_mismatch("flag_overflow", 32'(out_data.flag_overflow),
                          32'(want.flag_overflow));
        if (out_data.flag_zero !== want.flag_zero)
          report_mismatch("flag_zero", 32'(out_data.flag_zero), 32'(want.flag_zero));
        if (out_data.flag_negative !== want.flag_negative)
          report_mismatch("flag_negative", 32'(out_data.flag_negative),
                          32'(want.flag_negative));
        if (out_data.store_valid !== want.store_valid)
          report_mismatch("store_valid", 32'(out_data.store_valid), 32'(want.store_valid));
        if (out_data.store_address !== want.store_address)
          report_mismatch("store_address", 32'(out_data.store_address),
                          32'(want.store_address));
        if (out_data.store_data !== want.store_data)
          report_mismatch("store_data", 32'(out_data.store_data), 32'(want.store_data));
        if (out_data.cycles_taken !== want.cycles_taken)
          report_mismatch("cycles_taken", 32'(out_data.cycles_taken), 32'(want.cycles_taken));
        if (out_data.cycle_total !== want.cycle_total)
          report_mismatch("cycle_total", out_data.cycle_total, want.cycle_total);
        if (out_data.illegal_mode !== want.illegal_mode)
          report_mismatch("illegal_mode", 32'(out_data.illegal_mode), 32'(want.illegal_mode));
      end
      beats_taken++;
    end
  end

  // Receiver: random stalls per beat, and one long hold to back the block up.
  initial begin : receiver
    int unsigned stall;
    bit          held_long;
    out_ready = 1'b0;
    held_long = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = idle_cycles(beats_taken);
      if (!held_long && beats_taken >= 300) begin
        stall     = 80;
        held_long = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : sender
    int unsigned i;
    int unsigned pick;
    logic [7:0]  opnd;
    logic [15:0] addr;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    acc         = 8'h00;
    c_flag      = 1'b0;
    v_flag      = 1'b0;
    z_flag      = 1'b0;
    n_flag      = 1'b0;
    cycle_sum   = 32'd0;

    // Typed expectations are packed in field order: A, C, V, Z, N, store valid,
    // store address, store data, cycles, cycle total, illegal.
    directed_rows.push_back(row(OP_STA, MODE_IMM, 8'hA5, 16'h1234, 1'b1, 1'b1,
      {8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 3'd0, 32'd0, 1'b1}));
    directed_rows.push_back(row(OP_LDA, MODE_IMM, 8'h80, 16'h0000, 1'b0, 1'b1,
      {8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 3'd2, 32'd2, 1'b0}));
    directed_rows.push_back(row(OP_STA, 3'd0, 8'h00, 16'hFFFF, 1'b1, 1'b1,
      {8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 8'h80, 3'd6, 32'd8, 1'b0}));
    directed_rows.push_back(row(OP_LDA, 3'd1, 8'h00, 16'h00FF, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_ORA, 3'd0, 8'hFF, 16'hFF00, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_AND, 3'd3, 8'h0F, 16'h8000, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_EOR, 3'd4, 8'hFF, 16'h7FFF, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_LDA, MODE_IMM, 8'h7F, 16'h0001, 1'b1, 1'b0, '0));
    // Signed overflow, then unsigned carry out with a zero result.
    directed_rows.push_back(row(OP_ADC, 3'd5, 8'h01, 16'h5555, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_ADC, 3'd6, 8'h80, 16'hAAAA, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_ADC, 3'd7, 8'hFF, 16'h0100, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_LDA, 3'd7, 8'h50, 16'h01FF, 1'b1, 1'b0, '0));
    // Borrow out, then subtraction with the borrow taken in.
    directed_rows.push_back(row(OP_SBC, 3'd6, 8'hF0, 16'h2000, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_SBC, 3'd7, 8'h00, 16'h3000, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_LDA, 3'd2, 8'h80, 16'h4000, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_SBC, 3'd2, 8'h01, 16'h5000, 1'b0, 1'b0, '0));
    // Compare equal, below and above.
    directed_rows.push_back(row(OP_CMP, 3'd0, 8'h7F, 16'h6000, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_CMP, 3'd1, 8'h80, 16'h7000, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_CMP, 3'd5, 8'h00, 16'h9000, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_STA, 3'd1, 8'hFF, 16'h0000, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_STA, 3'd3, 8'h00, 16'h8001, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_STA, 3'd4, 8'hFF, 16'hFFFE, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_STA, 3'd5, 8'h00, 16'h00FF, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(OP_STA, 3'd6, 8'hFF, 16'hFF00, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(OP_STA, 3'd7, 8'h00, 16'h1357, 1'b0, 1'b0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < directed_rows.size(); i++) begin
      send_beat(directed_rows[i], i);
    end

    for (i = 0; i < RandomItems; i++) begin
      // After 600 random items, let everything in flight drain before going on.
      if (i == 600) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_results.size() != 0);
      end
      pick = $urandom_range(0, 4);
      opnd = ($urandom_range(0, 3) == 0) ? EDGE_BYTES[pick*8 +: 8] : 8'($urandom_range(0, 255));
      addr = ($urandom_range(0, 15) == 0) ? {16{opnd[0]}} : 16'($urandom_range(0, 65535));
      send_beat(row(op_e'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), opnd, addr,
                    1'($urandom_range(0, 1)), 1'b0, '0), i);
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[group_one_alu_6502] OK");
    end else begin
      $display("[group_one_alu_6502] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/gof_pkg.sv
hdl/gof_front.sv
hdl/gof_queue.sv
hdl/gof_exec.sv
hdl/group_one_alu_6502.sv
hdl/gof_checker.sv
sim/tb_group_one_alu_6502.sv
